>>> rtl/core/afr_pkg.sv
// ---------------------------------------------------------------------------
// afr_pkg - API frame receiver shared definitions
// Frame constants, API identifiers, result codes and the result item layout.
// ---------------------------------------------------------------------------
package afr_pkg;

   localparam int unsigned MAX_FRAME_BYTES = 128;

   localparam logic [7:0] ESC_BYTE     = 8'h7D;
   localparam logic [7:0] ESC_XOR      = 8'h20;
   localparam logic [7:0] SUM_GOOD     = 8'hFF;
   localparam logic [7:0] ID_TX_STATUS = 8'h89;
   localparam logic [7:0] ID_RX_64     = 8'h80;
   localparam logic [7:0] ID_RX_16     = 8'h81;
   localparam logic [7:0] ID_AT_RESP   = 8'h88;

   // First unescaped index of the API id byte
   localparam logic [7:0] IDX_API_ID   = 8'd3;

   typedef enum logic [2:0] {
      RC_OK       = 3'd0,
      RC_CHECKSUM = 3'd1,
      RC_UNKNOWN  = 3'd2,
      RC_TRUNC    = 3'd3,
      RC_OVERFLOW = 3'd4
   } result_code_type;

   typedef struct packed {
      logic            frame_done;
      logic [7:0]      data_byte;
      result_code_type result_code;
      logic [7:0]      api_id;
      logic [7:0]      frame_id;
      logic [7:0]      tx_status;
      logic [7:0]      rssi;
      logic [7:0]      rx_options;
      logic [63:0]     source_addr;
      logic [15:0]     at_command;
      logic [7:0]      payload_count;
   } result_type;

   function automatic logic is_known_id(input logic [7:0] id);
      return (id == ID_TX_STATUS) || (id == ID_RX_64) ||
             (id == ID_RX_16) || (id == ID_AT_RESP);
   endfunction

   // Smallest index of the checksum byte that still covers the fixed fields
   function automatic logic [7:0] min_final_index(input logic [7:0] id);
      logic [7:0] res;
      res = 8'd4;
      if (id == ID_TX_STATUS) begin
         res = 8'd6;
      end else if (id == ID_RX_64) begin
         res = 8'd14;
      end else if (id == ID_RX_16) begin
         res = 8'd8;
      end else if (id == ID_AT_RESP) begin
         res = 8'd8;
      end
      return res;
   endfunction

endpackage

>>> rtl/core/afr_if.sv
// ---------------------------------------------------------------------------
// afr_if - API frame receiver channels
// Valid/ready channels for raw received bytes and for result items.
// ---------------------------------------------------------------------------
interface afr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       last_byte;

   modport source (output valid, output rx_byte, output last_byte, input ready);
   modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

interface afr_rsp_if;
   logic        valid;
   logic        ready;
   logic        frame_done;
   logic [7:0]  data_byte;
   logic [2:0]  result_code;
   logic [7:0]  api_id;
   logic [7:0]  frame_id;
   logic [7:0]  tx_status;
   logic [7:0]  rssi;
   logic [7:0]  rx_options;
   logic [63:0] source_addr;
   logic [15:0] at_command;
   logic [7:0]  payload_count;

   modport source (output valid, output frame_done, output data_byte,
                   output result_code, output api_id, output frame_id,
                   output tx_status, output rssi, output rx_options,
                   output source_addr, output at_command, output payload_count,
                   input ready);
   modport sink   (input valid, input frame_done, input data_byte,
                   input result_code, input api_id, input frame_id,
                   input tx_status, input rssi, input rx_options,
                   input source_addr, input at_command, input payload_count,
                   output ready);
endinterface

>>> rtl/core/api_frame_receiver_unit.sv
// Each result is registered in the result buffer before it appears on rsp_if.
// Throughput: one raw byte per cycle while the result buffer is not full; the frame state updates in one pass.
// A two-entry result buffer keeps req_if ready while one result waits.
// Reset (synchronous, active high) clears the frame state and empties the
// result buffer; no clearing pass is needed.
// ---------------------------------------------------------------------------
// api_frame_receiver_unit - escaped API frame receiver
// Unescapes raw bytes, checks the frame checksum, captures header fields by
// API id, streams payload bytes and closes each frame with a summary item.
// ---------------------------------------------------------------------------
module api_frame_receiver_unit (
   input logic   clock,
   input logic   reset,
   afr_req_if.sink   req_if,
   afr_rsp_if.source rsp_if
);
   import afr_pkg::*;

   localparam logic [7:0] MAX_IDX = 8'(MAX_FRAME_BYTES);

   // Frame state
   logic        escape_ff,     escape_in;
   logic [7:0]  index_ff,      index_in;
   logic [7:0]  sum_ff,        sum_in;
   logic        held_ff,       held_in;
   logic [7:0]  api_ff,        api_in;
   logic [7:0]  frame_id_ff,   frame_id_in;
   logic [7:0]  status_ff,     status_in;
   logic [7:0]  rssi_ff,       rssi_in;
   logic [7:0]  options_ff,    options_in;
   logic [63:0] addr_ff,       addr_in;
   logic [15:0] cmd_ff,        cmd_in;
   logic [7:0]  count_ff,      count_in;
   logic        overflow_ff,   overflow_in;

   // Result buffer: slot 0 is the head shown on rsp_if
   result_type  slot_ff [2];
   logic [1:0]  fill_ff;

   logic        accept;
   logic        pop;
   logic        push;
   logic        produce;
   result_type  res;

   // Working values for the current item
   logic [7:0]  b;
   logic        summary;
   logic        esc_trunc;
   logic [7:0]  fidx;
   result_code_type code;

   assign req_if.ready = (fill_ff != 2'd2);
   assign accept       = req_if.valid && req_if.ready;
   assign pop          = rsp_if.valid && rsp_if.ready;
   assign push         = accept && produce;

   // -----------------------------------------------------------------------
   // One pass over the accepted byte
   // -----------------------------------------------------------------------
   always_comb begin
      escape_in   = escape_ff;
      index_in    = index_ff;
      sum_in      = sum_ff;
      held_in     = held_ff;
      api_in      = api_ff;
      frame_id_in = frame_id_ff;
      status_in   = status_ff;
      rssi_in     = rssi_ff;
      options_in  = options_ff;
      addr_in     = addr_ff;
      cmd_in      = cmd_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      b           = req_if.rx_byte;
      summary     = 1'b0;
      esc_trunc   = 1'b0;
      produce     = 1'b0;
      res         = '0;

      if (!escape_ff && req_if.rx_byte == ESC_BYTE) begin
         // escape marker: wait for the next byte, or close a cut-off frame
         if (req_if.last_byte) begin
            summary   = 1'b1;
            esc_trunc = 1'b1;
         end else begin
            escape_in = 1'b1;
         end
      end else begin
         if (escape_ff) begin
            b = req_if.rx_byte ^ ESC_XOR;
         end
         escape_in = 1'b0;

         if (index_ff >= MAX_IDX) begin
            // frame too long: the byte is dropped
            overflow_in = 1'b1;
            summary     = req_if.last_byte;
         end else begin
            index_in = index_ff + 8'd1;
            held_in  = 1'b1;
            if (index_ff >= IDX_API_ID) begin
               sum_in = sum_ff + b;
            end

            if (req_if.last_byte) begin
               summary = 1'b1;
            end else if (index_ff == IDX_API_ID) begin
               api_in = b;
            end else if (index_ff > IDX_API_ID) begin
               unique case (api_ff)
                  ID_TX_STATUS: begin
                     if (index_ff == 8'd4) begin
                        frame_id_in = b;
                     end else if (index_ff == 8'd5) begin
                        status_in = b;
                     end
                  end
                  ID_RX_64: begin
                     if (index_ff <= 8'd11) begin
                        addr_in = {addr_ff[55:0], b};
                     end else if (index_ff == 8'd12) begin
                        rssi_in = b;
                     end else if (index_ff == 8'd13) begin
                        options_in = b;
                     end else begin
                        produce = 1'b1;
                     end
                  end
                  ID_RX_16: begin
                     if (index_ff <= 8'd5) begin
                        addr_in = {48'd0, addr_ff[7:0], b};
                     end else if (index_ff == 8'd6) begin
                        rssi_in = b;
                     end else if (index_ff == 8'd7) begin
                        options_in = b;
                     end else begin
                        produce = 1'b1;
                     end
                  end
                  ID_AT_RESP: begin
                     if (index_ff == 8'd4) begin
                        frame_id_in = b;
                     end else if (index_ff <= 8'd6) begin
                        cmd_in = {cmd_ff[7:0], b};
                     end else if (index_ff == 8'd7) begin
                        status_in = b;
                     end else begin
                        produce = 1'b1;
                     end
                  end
                  default: begin
                     // unknown id: nothing past the id byte is kept
                  end
               endcase
               if (produce) begin
                  res.data_byte = b;
                  count_in      = count_ff + 8'd1;
               end
            end
         end
      end

      // Summary code, judged on the state including this byte
      fidx = index_in - 8'd1;
      if (overflow_in) begin
         code = RC_OVERFLOW;
      end else if (esc_trunc || !held_in || fidx < 8'd4) begin
         code = RC_TRUNC;
      end else if (sum_in != SUM_GOOD) begin
         code = RC_CHECKSUM;
      end else if (!is_known_id(api_ff)) begin
         code = RC_UNKNOWN;
      end else if (fidx < min_final_index(api_ff)) begin
         code = RC_TRUNC;
      end else begin
         code = RC_OK;
      end

      if (summary) begin
         produce           = 1'b1;
         res.frame_done    = 1'b1;
         res.result_code   = code;
         res.api_id        = api_ff;
         res.frame_id      = frame_id_ff;
         res.tx_status     = status_ff;
         res.rssi          = rssi_ff;
         res.rx_options    = options_ff;
         res.source_addr   = addr_ff;
         res.at_command    = cmd_ff;
         res.payload_count = count_ff;
         // frame closed: start the next one clean
         escape_in   = 1'b0;
         index_in    = '0;
         sum_in      = '0;
         held_in     = 1'b0;
         api_in      = '0;
         frame_id_in = '0;
         status_in   = '0;
         rssi_in     = '0;
         options_in  = '0;
         addr_in     = '0;
         cmd_in      = '0;
         count_in    = '0;
         overflow_in = 1'b0;
      end
   end

   // -----------------------------------------------------------------------
   // Frame state registers
   // -----------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff   <= 1'b0;
         index_ff    <= '0;
         sum_ff      <= '0;
         held_ff     <= 1'b0;
         api_ff      <= '0;
         frame_id_ff <= '0;
         status_ff   <= '0;
         rssi_ff     <= '0;
         options_ff  <= '0;
         addr_ff     <= '0;
         cmd_ff      <= '0;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else if (accept) begin
         escape_ff   <= escape_in;
         index_ff    <= index_in;
         sum_ff      <= sum_in;
         held_ff     <= held_in;
         api_ff      <= api_in;
         frame_id_ff <= frame_id_in;
         status_ff   <= status_in;
         rssi_ff     <= rssi_in;
         options_ff  <= options_in;
         addr_ff     <= addr_in;
         cmd_ff      <= cmd_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   // -----------------------------------------------------------------------
   // Two-entry result buffer
   // -----------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (push && !pop) begin
         fill_ff <= fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_ff <= fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !pop) begin
         slot_ff[fill_ff[0]] <= res;
      end else if (pop) begin
         if (push) begin
            // a push never meets a full buffer, so fill is one here
            slot_ff[0] <= res;
         end else begin
            slot_ff[0] <= slot_ff[1];
         end
      end
   end

   assign rsp_if.valid         = (fill_ff != 2'd0);
   assign rsp_if.frame_done    = slot_ff[0].frame_done;
   assign rsp_if.data_byte     = slot_ff[0].data_byte;
   assign rsp_if.result_code   = slot_ff[0].result_code;
   assign rsp_if.api_id        = slot_ff[0].api_id;
   assign rsp_if.frame_id      = slot_ff[0].frame_id;
   assign rsp_if.tx_status     = slot_ff[0].tx_status;
   assign rsp_if.rssi          = slot_ff[0].rssi;
   assign rsp_if.rx_options    = slot_ff[0].rx_options;
   assign rsp_if.source_addr   = slot_ff[0].source_addr;
   assign rsp_if.at_command    = slot_ff[0].at_command;
   assign rsp_if.payload_count = slot_ff[0].payload_count;

`ifndef SYNTHESIS
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff != 2'd3)
      else $error("result buffer fill out of range");

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      index_ff <= MAX_IDX)
      else $error("byte index past frame limit");

   a_overflow_index: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> index_ff == MAX_IDX)
      else $error("overflow flagged below frame limit");

   a_summary_clears: assert property (@(posedge clock) disable iff (reset)
      push && res.frame_done |=> index_ff == 8'd0 && !escape_ff && !held_ff)
      else $error("frame state not cleared after summary");

   a_payload_id: assert property (@(posedge clock) disable iff (reset)
      push && !res.frame_done |->
         (api_ff == ID_RX_64 || api_ff == ID_RX_16 || api_ff == ID_AT_RESP))
      else $error("payload item for an id that carries none");
`endif

endmodule
